[rtl/etl_pkg.sv]
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types and constants for the expression token lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

	localparam int POS_W   = 16;
	localparam int OUT_W   = 24;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_PLUS    = 3'd1,
		KIND_MINUS   = 3'd2,
		KIND_OPEN    = 3'd3,
		KIND_CLOSE   = 3'd4,
		KIND_END     = 3'd5,
		KIND_UNKNOWN = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   line;
		logic [POS_W-1:0]   column;
		logic [OUT_W-1:0]   offset;
		logic [OUT_W-1:0]   length;
		logic [OUT_W-1:0]   line_start;
		logic               last;
	} token_t;

	// Tokens caused by one byte: zero, one or two, oldest in first.
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} batch_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              room;
	} qstat_t;

endpackage

[rtl/etl_channels.sv]
// ----------------------------------------------------------------------------
// etl_channels
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface etl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;

	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface etl_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [23:0] token_offset;
	logic [23:0] token_length;
	logic [23:0] line_start_offset;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_line, output token_column,
		output token_offset, output token_length, output line_start_offset,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_line, input token_column,
		input token_offset, input token_length, input line_start_offset,
		input last_of_run, output ready);
endinterface

[rtl/etl_core.sv]
// ----------------------------------------------------------------------------
// etl_core
// Input register, position tracking and token classification per byte.
// ----------------------------------------------------------------------------
module etl_core
	import etl_pkg::*;
#(
	parameter int TAB_WIDTH   = 8,
	parameter int OFFSET_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	etl_byte_if.sink     source,
	input  logic         room,
	output batch_t       batch
);

	localparam int PH_W  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int EXT_W = (OFFSET_BITS > OUT_W) ? OFFSET_BITS : OUT_W;
	localparam logic [PH_W-1:0] SAT_PHASE = PH_W'((2**POS_W - 2) % TAB_WIDTH);
	localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(TAB_WIDTH - 1);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[OUT_W-1:0];
	endfunction

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go;

	logic [OFFSET_BITS-1:0] ofs_q, ls_q, num_ofs_q, num_ls_q, num_len_q;
	logic [POS_W-1:0]       line_q, col_q, num_line_q, num_col_q;
	logic [PH_W-1:0]        phase_q;
	logic                   in_num_q, finished_q;

	logic [OFFSET_BITS-1:0] ofs_d, ls_d, num_ofs_d, num_ls_d, num_len_d;
	logic [POS_W-1:0]       line_d, col_d, num_line_d, num_col_d;
	logic [PH_W-1:0]        phase_d;
	logic                   in_num_d, finished_d;

	logic        is_digit, is_space, has_num, has_one;
	logic [POS_W:0] tab_sum;
	kind_t       one_kind;
	token_t      num_tok, one_tok;

	assign source.ready = !valid_s1 || room;
	assign go = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (source.ready) begin
			valid_s1 <= source.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (source.valid && source.ready) begin
			byte_s1 <= source.source_byte;
		end
	end

	always_comb begin
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		is_space = (byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) || (byte_s1 == CH_LF) ||
			(byte_s1 == CH_VT) || (byte_s1 == CH_FF) || (byte_s1 == CH_CR);
		unique case (byte_s1)
			CH_PLUS:  one_kind = KIND_PLUS;
			CH_MINUS: one_kind = KIND_MINUS;
			CH_OPEN:  one_kind = KIND_OPEN;
			CH_CLOSE: one_kind = KIND_CLOSE;
			CH_NUL:   one_kind = KIND_END;
			default:  one_kind = KIND_UNKNOWN;
		endcase
		has_num = !is_digit && in_num_q;
		has_one = !is_digit && !is_space;
		tab_sum = {1'b0, col_q} + (POS_W+1)'(TAB_WIDTH) - (POS_W+1)'(phase_q);
	end

	// Position effect of the byte; every byte taken while not finished steps past.
	always_comb begin
		ofs_d   = ofs_q + OFFSET_BITS'(1);
		ls_d    = ls_q;
		line_d  = line_q;
		col_d   = col_q;
		phase_d = phase_q;
		priority if (byte_s1 == CH_LF) begin
			ls_d    = ofs_q + OFFSET_BITS'(1);
			line_d  = (line_q != POS_MAX) ? line_q + POS_W'(1) : line_q;
			col_d   = POS_W'(1);
			phase_d = '0;
		end else if (byte_s1 == CH_CR) begin
			col_d   = POS_W'(1);
			phase_d = '0;
		end else if (byte_s1 == CH_TAB) begin
			if (tab_sum[POS_W]) begin
				col_d   = POS_MAX;
				phase_d = SAT_PHASE;
			end else begin
				col_d   = tab_sum[POS_W-1:0];
				phase_d = '0;
			end
		end else if (col_q != POS_MAX) begin
			col_d   = col_q + POS_W'(1);
			phase_d = (phase_q == LAST_PHASE) ? '0 : phase_q + PH_W'(1);
		end
	end

	always_comb begin
		in_num_d   = in_num_q;
		num_line_d = num_line_q;
		num_col_d  = num_col_q;
		num_ofs_d  = num_ofs_q;
		num_ls_d   = num_ls_q;
		num_len_d  = num_len_q;
		finished_d = finished_q;
		if (is_digit) begin
			if (!in_num_q) begin
				in_num_d   = 1'b1;
				num_line_d = line_q;
				num_col_d  = col_q;
				num_ofs_d  = ofs_q;
				num_ls_d   = ls_q;
				num_len_d  = OFFSET_BITS'(1);
			end else if (num_len_q != '1) begin
				num_len_d = num_len_q + OFFSET_BITS'(1);
			end
		end else begin
			in_num_d = 1'b0;
			if (has_one && (one_kind == KIND_END || one_kind == KIND_UNKNOWN)) begin
				finished_d = 1'b1;
			end
		end
	end

	always_comb begin
		num_tok.kind       = KIND_NUMBER;
		num_tok.line       = num_line_q;
		num_tok.column     = num_col_q;
		num_tok.offset     = to_out(num_ofs_q);
		num_tok.length     = to_out(num_len_q);
		num_tok.line_start = to_out(num_ls_q);
		num_tok.last       = !has_one;

		one_tok.kind       = one_kind;
		one_tok.line       = line_q;
		one_tok.column     = col_q;
		one_tok.offset     = to_out(ofs_q);
		one_tok.length     = OUT_W'(1);
		one_tok.line_start = to_out(ls_q);
		one_tok.last       = 1'b1;

		batch.first  = has_num ? num_tok : one_tok;
		batch.second = one_tok;
		batch.count  = '0;
		if (go && !finished_q) begin
			batch.count = 2'(has_num) + 2'(has_one);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q      <= '0;
			ls_q       <= '0;
			line_q     <= POS_W'(1);
			col_q      <= POS_W'(1);
			phase_q    <= '0;
			in_num_q   <= 1'b0;
			num_line_q <= POS_W'(1);
			num_col_q  <= POS_W'(1);
			num_ofs_q  <= '0;
			num_ls_q   <= '0;
			num_len_q  <= '0;
			finished_q <= 1'b0;
		end else if (go && !finished_q) begin
			ofs_q      <= ofs_d;
			ls_q       <= ls_d;
			line_q     <= line_d;
			col_q      <= col_d;
			phase_q    <= phase_d;
			in_num_q   <= in_num_d;
			num_line_q <= num_line_d;
			num_col_q  <= num_col_d;
			num_ofs_q  <= num_ofs_d;
			num_ls_q   <= num_ls_d;
			num_len_q  <= num_len_d;
			finished_q <= finished_d;
		end
	end

endmodule

[rtl/etl_queue.sv]
// ----------------------------------------------------------------------------
// etl_queue
// Small result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module etl_queue
	import etl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  batch_t       batch,
	etl_token_if.source  token,
	output qstat_t       stat
);

	token_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] level_q;
	logic              pop;
	token_t            head;

	assign pop  = token.valid && token.ready;
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (batch.count != 2'd0) begin
			mem[wr_q] <= batch.first;
		end
		if (batch.count == 2'd2) begin
			mem[wr_q + QPTR_W'(1)] <= batch.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(batch.count);
			rd_q    <= rd_q + QPTR_W'(pop);
			level_q <= level_q + QCNT_W'(batch.count) - QCNT_W'(pop);
		end
	end

	// Leave room for the worst case of two tokens from one byte.
	assign stat.level = level_q;
	assign stat.room  = level_q <= QCNT_W'(QDEPTH - 2);

	assign token.valid             = level_q != '0;
	assign token.token_kind        = head.kind;
	assign token.token_line        = head.line;
	assign token.token_column      = head.column;
	assign token.token_offset      = head.offset;
	assign token.token_length      = head.length;
	assign token.line_start_offset = head.line_start;
	assign token.last_of_run       = head.last;

endmodule

[rtl/expression_token_lexer_unit.sv]
// The lexer takes one source byte per cycle and returns tokens with line, column,
// offset, length and line start. A byte is held in the input register, where it
// is classified and the position state is updated, until the four-entry result
// queue has room for its tokens and they are written into it. Bytes flow at one
// per cycle as long as the queue has two free entries, so the input stalls only
// when tokens are not taken as fast as they are produced (a number ended by an
// operator yields two). After an end or unknown token every byte is accepted
// and dropped until reset. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// expression_token_lexer_unit
// Byte-serial tokenizer for arithmetic expressions.
// ----------------------------------------------------------------------------
module expression_token_lexer_unit
	import etl_pkg::*;
#(
	parameter int TAB_WIDTH   = 8,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	etl_byte_if.sink    source,
	etl_token_if.source token
);

	batch_t batch;
	qstat_t stat;

	etl_core #(
		.TAB_WIDTH   (TAB_WIDTH),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.source (source),
		.room   (stat.room),
		.batch  (batch)
	);

	etl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (batch),
		.token  (token),
		.stat   (stat)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= QCNT_W'(QDEPTH))
		else $error("result queue over depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		batch.count != 2'd0 |-> stat.room)
		else $error("tokens pushed without room");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		batch.count == 2'd2 |-> batch.first.kind == KIND_NUMBER && !batch.first.last)
		else $error("token pair not led by number");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && (token.token_kind == KIND_END || token.token_kind == KIND_UNKNOWN)
		|-> token.last_of_run)
		else $error("terminating token not marked last");

endmodule

[tb/tb_expression_token_lexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_token_lexer_unit
// Feeds source bytes through the lexer and checks every token against typed
// values for the first table rows, else against a behavioral lexer kept in
// step with the accepted bytes. A short table of hand-picked bytes opens the
// run; random expression text follows. It ends with an end or unknown token
// and a tail of bytes that must be dropped. Both handshakes stall at random outside a calm stretch.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer_unit;
	import etl_pkg::*;

	localparam int TAB_W       = 8;
	localparam int STALL_PCT   = 29;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PROBE_ROWS  = 20;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct {
		logic [7:0] ch;
		int         typed;   // number of typed tokens, or -1 to use the lexer model
		token_t     first;
		token_t     second;
	} probe_row_t;

	logic clk;
	logic arst_n;
	bit   calm;
	int   failures;
	int   cycle_count;

	etl_byte_if  byte_ch();
	etl_token_if token_ch();

	expression_token_lexer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.source (byte_ch),
		.token  (token_ch)
	);

	// lexer position and number-run state
	logic [23:0] pos_offset;
	logic [15:0] pos_line;
	logic [15:0] pos_column;
	logic [23:0] pos_line_start;
	bit          num_open;
	logic [15:0] num_line;
	logic [15:0] num_column;
	logic [23:0] num_offset;
	logic [23:0] num_line_start;
	logic [23:0] num_length;
	bit          lex_done;

	token_t     pending_tokens[$];
	probe_row_t probe_rows[PROBE_ROWS];

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	function automatic token_t tk(kind_t k, logic [15:0] line, logic [15:0] column,
		logic [23:0] offset, logic [23:0] length, logic [23:0] line_start, logic last);
		token_t t;
		t.kind       = k;
		t.line       = line;
		t.column     = column;
		t.offset     = offset;
		t.length     = length;
		t.line_start = line_start;
		t.last       = last;
		return t;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
			|| c == CH_CR;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic step_position(input logic [7:0] c);
		int unsigned col;
		if (c == CH_LF) begin
			pos_line_start = pos_offset + 24'd1;
			if (pos_line != 16'hFFFF)
				pos_line = pos_line + 16'd1;
			pos_column = 16'd1;
		end else if (c == CH_CR) begin
			pos_column = 16'd1;
		end else if (c == CH_TAB) begin
			col = pos_column + TAB_W - ((pos_column - 1) % TAB_W);
			pos_column = (col > 65535) ? 16'hFFFF : col[15:0];
		end else if (pos_column != 16'hFFFF) begin
			pos_column = pos_column + 16'd1;
		end
		pos_offset = pos_offset + 24'd1;
	endtask

	// Work out the tokens one byte causes; queue them when keep is set.
	task automatic lex_byte(input logic [7:0] c, input bit keep);
		kind_t  kind;
		token_t found[$];
		if (lex_done)
			return;
		if (is_digit(c)) begin
			if (!num_open) begin
				num_open       = 1'b1;
				num_line       = pos_line;
				num_column     = pos_column;
				num_offset     = pos_offset;
				num_line_start = pos_line_start;
				num_length     = 24'd0;
			end
			if (num_length != 24'hFFFFFF)
				num_length = num_length + 24'd1;
			step_position(c);
			return;
		end
		if (num_open) begin
			found.push_back(tk(KIND_NUMBER, num_line, num_column, num_offset, num_length,
				num_line_start, 1'b0));
			num_open = 1'b0;
		end
		if (is_blank(c)) begin
			step_position(c);
		end else begin
			case (c)
				CH_PLUS: kind = KIND_PLUS;
				CH_MINUS: kind = KIND_MINUS;
				CH_OPEN: kind = KIND_OPEN;
				CH_CLOSE: kind = KIND_CLOSE;
				CH_NUL: kind = KIND_END;
				default: kind = KIND_UNKNOWN;
			endcase
			found.push_back(tk(kind, pos_line, pos_column, pos_offset, 24'd1,
				pos_line_start, 1'b0));
			step_position(c);
			if (kind == KIND_END || kind == KIND_UNKNOWN)
				lex_done = 1'b1;
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		if (keep)
			foreach (found[i])
				pending_tokens.push_back(found[i]);
	endtask

	task automatic feed(input logic [7:0] c, input bit keep);
		@(negedge clk);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.source_byte <= c;
		do @(posedge clk); while (!byte_ch.ready);
		lex_byte(c, keep);
	endtask

	task automatic feed_random_text();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			feed(CH_ZERO + 8'($urandom_range(9)), 1'b1);
		end else if (pick < 62) begin
			case ($urandom_range(3))
				0: feed(CH_PLUS, 1'b1);
				1: feed(CH_MINUS, 1'b1);
				2: feed(CH_OPEN, 1'b1);
				default: feed(CH_CLOSE, 1'b1);
			endcase
		end else begin
			case ($urandom_range(7))
				0, 1: feed(CH_SPACE, 1'b1);
				2: feed(CH_TAB, 1'b1);
				3, 4: feed(CH_LF, 1'b1);
				5: feed(CH_CR, 1'b1);
				6: feed(CH_VT, 1'b1);
				default: feed(CH_FF, 1'b1);
			endcase
		end
	endtask

	always @(negedge clk) begin
		token_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			got = tk(kind_t'(token_ch.token_kind), token_ch.token_line, token_ch.token_column,
				token_ch.token_offset, token_ch.token_length, token_ch.line_start_offset,
				token_ch.last_of_run);
			if (pending_tokens.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected token: kind %0d line %0d col %0d ofs %0d len %0d",
						got.kind, got.line, got.column, got.offset, got.length);
			end else begin
				want = pending_tokens.pop_front();
				if (got.kind !== want.kind || got.line !== want.line
					|| got.column !== want.column || got.offset !== want.offset
					|| got.length !== want.length || got.line_start !== want.line_start
					|| got.last !== want.last) begin
					failures++;
					if (failures <= 10) begin
						$display("token mismatch: expected kind %0d line %0d col %0d ofs %0d len %0d ls %0d last %0d",
							want.kind, want.line, want.column, want.offset, want.length,
							want.line_start, want.last);
						$display("                actual   kind %0d line %0d col %0d ofs %0d len %0d ls %0d last %0d",
							got.kind, got.line, got.column, got.offset, got.length,
							got.line_start, got.last);
					end
				end
			end
		end
	end

	initial begin
		logic [7:0] c;
		arst_n              = 1'b0;
		calm                = 1'b0;
		failures            = 0;
		cycle_count         = 0;
		byte_ch.valid       = 1'b0;
		byte_ch.source_byte = 8'h00;
		token_ch.ready      = 1'b0;
		pos_offset          = 24'd0;
		pos_line            = 16'd1;
		pos_column          = 16'd1;
		pos_line_start      = 24'd0;
		num_open            = 1'b0;
		num_line            = 16'd1;
		num_column          = 16'd1;
		num_offset          = 24'd0;
		num_line_start      = 24'd0;
		num_length          = 24'd0;
		lex_done            = 1'b0;

		probe_rows[0]  = '{CH_PLUS, 1, tk(KIND_PLUS, 16'd1, 16'd1, 24'd0, 24'd1, 24'd0, 1'b1), '0};
		probe_rows[1]  = '{CH_NINE, 0, '0, '0};
		probe_rows[2]  = '{CH_ZERO, 0, '0, '0};
		probe_rows[3]  = '{CH_MINUS, 2,
			tk(KIND_NUMBER, 16'd1, 16'd2, 24'd1, 24'd2, 24'd0, 1'b0),
			tk(KIND_MINUS, 16'd1, 16'd4, 24'd3, 24'd1, 24'd0, 1'b1)};
		probe_rows[4]  = '{CH_TAB, -1, '0, '0};
		probe_rows[5]  = '{CH_OPEN, -1, '0, '0};
		probe_rows[6]  = '{CH_SPACE, -1, '0, '0};
		probe_rows[7]  = '{CH_VT, -1, '0, '0};
		probe_rows[8]  = '{CH_FF, -1, '0, '0};
		probe_rows[9]  = '{CH_CR, -1, '0, '0};
		probe_rows[10] = '{CH_ZERO + 8'd5, -1, '0, '0};
		probe_rows[11] = '{CH_SPACE, -1, '0, '0};
		probe_rows[12] = '{CH_LF, -1, '0, '0};
		probe_rows[13] = '{CH_ZERO + 8'd7, -1, '0, '0};
		probe_rows[14] = '{CH_LF, -1, '0, '0};
		probe_rows[15] = '{CH_CLOSE, -1, '0, '0};
		probe_rows[16] = '{CH_ZERO, -1, '0, '0};
		probe_rows[17] = '{CH_NINE, -1, '0, '0};
		probe_rows[18] = '{CH_OPEN, -1, '0, '0};
		probe_rows[19] = '{CH_ZERO + 8'd3, -1, '0, '0};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (probe_rows[i]) begin
			if (probe_rows[i].typed > 0)
				pending_tokens.push_back(probe_rows[i].first);
			if (probe_rows[i].typed > 1)
				pending_tokens.push_back(probe_rows[i].second);
			feed(probe_rows[i].ch, probe_rows[i].typed < 0);
		end

		// hold the sender until every queued token has drained
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 400 && i < 600);
			feed_random_text();
		end

		feed(CH_ZERO + 8'd7, 1'b1);
		feed(CH_PLUS, 1'b1);
		repeat (3) feed(CH_SPACE, 1'b1);
		feed(CH_MINUS, 1'b1);
		feed(CH_OPEN, 1'b1);
		feed(CH_ZERO + 8'd4, 1'b1);
		feed(CH_ZERO + 8'd2, 1'b1);
		feed(CH_CLOSE, 1'b1);
		repeat (20) feed_random_text();

		// finish with an end token, a number and end token, or an unknown byte
		case ($urandom_range(2))
			0: feed(CH_NUL, 1'b1);
			1: begin
				feed(CH_ZERO + 8'd3, 1'b1);
				feed(CH_ZERO + 8'd1, 1'b1);
				feed(CH_NUL, 1'b1);
			end
			default: begin
				do c = 8'($urandom_range(1, 255));
				while (is_digit(c) || is_blank(c) || c == CH_PLUS || c == CH_MINUS
					|| c == CH_OPEN || c == CH_CLOSE);
				feed(c, 1'b1);
			end
		endcase

		// drop everything after the final token
		feed(8'hFF, 1'b1);
		feed(8'h00, 1'b1);
		repeat (48) feed(8'($urandom_range(255)), 1'b1);

		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_tokens.size() != 0)
			failures++;

		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[expression_token_lexer_unit.f]
rtl/etl_pkg.sv
rtl/etl_channels.sv
rtl/etl_core.sv
rtl/etl_queue.sv
rtl/expression_token_lexer_unit.sv
tb/tb_expression_token_lexer_unit.sv
